[design/vsrt_pkg.sv]
package vsrt_pkg;

  localparam int TRIG_DEPTH = 2881;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint RAD_PER_UNIT_Q30 = 64'sd292818;

  typedef logic signed [17:0] coef_t;
  typedef coef_t [8:0] mat_t;
  typedef logic signed [15:0] angle_t;
  typedef angle_t [2:0] angles_t;

  typedef struct packed {
    logic [47:0]        scale;
    logic signed [31:0] off_x;
    logic signed [31:0] off_y;
    logic signed [31:0] off_z;
  } cfg_t;

  typedef enum logic [2:0] {
    CFG_ANGLE_X,
    CFG_ANGLE_Y,
    CFG_ANGLE_Z,
    CFG_SCALE,
    CFG_OFFSET_X,
    CFG_OFFSET_Y,
    CFG_OFFSET_Z
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_ROM,
    ST_QUAD,
    ST_MUL1,
    ST_MUL2,
    ST_ACC
  } mg_state_t;

  typedef enum logic [3:0] {
    OPD_SX, OPD_CX, OPD_SY, OPD_CY, OPD_SZ, OPD_CZ, OPD_K, OPD_NK, OPD_ZERO
  } opd_t;

  typedef struct packed {
    opd_t a1;
    opd_t b1;
    opd_t c1;
    opd_t a2;
    opd_t b2;
    opd_t c2;
  } ent_ops_t;

  // each matrix entry is a1*b1*c1 + a2*b2*c2 at Q48
  function automatic ent_ops_t ent_ops(logic [3:0] e);
    ent_ops_t o;
    o = '{OPD_ZERO, OPD_ZERO, OPD_ZERO, OPD_ZERO, OPD_ZERO, OPD_ZERO};
    case (e)
      4'd0: o = '{OPD_CZ, OPD_CY, OPD_K, OPD_ZERO, OPD_ZERO, OPD_ZERO};
      4'd1: o = '{OPD_CZ, OPD_SY, OPD_SX, OPD_SZ, OPD_CX, OPD_NK};
      4'd2: o = '{OPD_CZ, OPD_SY, OPD_CX, OPD_SZ, OPD_SX, OPD_K};
      4'd3: o = '{OPD_SZ, OPD_CY, OPD_K, OPD_ZERO, OPD_ZERO, OPD_ZERO};
      4'd4: o = '{OPD_SZ, OPD_SY, OPD_SX, OPD_CZ, OPD_CX, OPD_K};
      4'd5: o = '{OPD_SZ, OPD_SY, OPD_CX, OPD_CZ, OPD_SX, OPD_NK};
      4'd6: o = '{OPD_SY, OPD_K, OPD_NK, OPD_ZERO, OPD_ZERO, OPD_ZERO};
      4'd7: o = '{OPD_CY, OPD_SX, OPD_K, OPD_ZERO, OPD_ZERO, OPD_ZERO};
      4'd8: o = '{OPD_CY, OPD_CX, OPD_K, OPD_ZERO, OPD_ZERO, OPD_ZERO};
      default: o = '{OPD_ZERO, OPD_ZERO, OPD_ZERO, OPD_ZERO, OPD_ZERO, OPD_ZERO};
    endcase
    return o;
  endfunction

  typedef logic [33:0] trig_word_t;
  typedef trig_word_t trig_rom_t [TRIG_DEPTH];

  // sine in bits 33..17, cosine in 16..0, both Q16, for one eighth turn
  function automatic trig_word_t trig_entry(int u);
    longint x;
    longint x2;
    longint t;
    longint s;
    longint c;
    x = longint'(u) * RAD_PER_UNIT_Q30;
    x2 = (x * x) >>> 30;
    t = ONE_Q30 - x2 / 42;
    t = ONE_Q30 - ((x2 * t) >>> 30) / 20;
    t = ONE_Q30 - ((x2 * t) >>> 30) / 6;
    s = (((x * t) >>> 30) + 64'sd8192) >>> 14;
    t = ONE_Q30 - x2 / 56;
    t = ONE_Q30 - ((x2 * t) >>> 30) / 30;
    t = ONE_Q30 - ((x2 * t) >>> 30) / 12;
    t = ONE_Q30 - ((x2 * t) >>> 30) / 2;
    c = (t + 64'sd8192) >>> 14;
    return {s[16:0], c[16:0]};
  endfunction

  function automatic trig_rom_t build_trig_rom();
    trig_rom_t r;
    for (int i = 0; i < TRIG_DEPTH; i++) begin
      r[i] = trig_entry(i);
    end
    return r;
  endfunction

endpackage

[design/vsrt_in_if.sv]
interface vsrt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vert_x;
  logic signed [31:0] vert_y;
  logic signed [31:0] vert_z;
  modport source (output valid, vert_x, vert_y, vert_z, input ready);
  modport sink (input valid, vert_x, vert_y, vert_z, output ready);
  modport mon (input valid, ready, vert_x, vert_y, vert_z);
endinterface

[design/vsrt_out_if.sv]
interface vsrt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               clipped;
  modport source (output valid, out_x, out_y, out_z, clipped, input ready);
  modport sink (input valid, out_x, out_y, out_z, clipped, output ready);
  modport mon (input valid, ready, out_x, out_y, out_z, clipped);
endinterface

[design/vsrt_matrix_gen.sv]
module vsrt_matrix_gen (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  vsrt_pkg::angles_t angles,
  output logic            busy,
  output vsrt_pkg::mat_t  mat
);
  import vsrt_pkg::*;

  localparam trig_rom_t TRIG_ROM = build_trig_rom();

  mg_state_t          state_r, state_nxt;
  logic [1:0]         ax_r, ax_nxt;
  logic [3:0]         ent_r, ent_nxt;
  logic               mat_we;
  mat_t               mat_r;
  logic [11:0]        u_r;
  logic [1:0]         q_r;
  logic               swap_r;
  trig_word_t         rom_q_r;
  coef_t              sin_r [3];
  coef_t              cos_r [3];
  logic signed [35:0] pa_r, pb_r;
  logic signed [53:0] ta_r, tb_r;

  logic signed [16:0] a_ext, m_s;
  logic [14:0]        m_u;
  logic [1:0]         q_c;
  logic [12:0]        r_c;
  logic [11:0]        u_c;
  logic               swap_c;
  coef_t              s0, c0, sin_c, cos_c;
  coef_t              opv [9];
  ent_ops_t           ops;
  logic signed [54:0] v_sum, v_rnd;
  logic signed [22:0] ent_wide;
  coef_t              ent_val;

  // reduce the angle to one turn, then to quadrant and an eighth turn
  always_comb begin
    a_ext = {angles[ax_r][15], angles[ax_r]};
    if (a_ext < -17'sd23040) begin
      m_s = a_ext + 17'sd46080;
    end else if (a_ext < 17'sd0) begin
      m_s = a_ext + 17'sd23040;
    end else if (a_ext >= 17'sd23040) begin
      m_s = a_ext - 17'sd23040;
    end else begin
      m_s = a_ext;
    end
    m_u = m_s[14:0];
    if (m_u >= 15'd17280) begin
      q_c = 2'd3;
      r_c = 13'(m_u - 15'd17280);
    end else if (m_u >= 15'd11520) begin
      q_c = 2'd2;
      r_c = 13'(m_u - 15'd11520);
    end else if (m_u >= 15'd5760) begin
      q_c = 2'd1;
      r_c = 13'(m_u - 15'd5760);
    end else begin
      q_c = 2'd0;
      r_c = 13'(m_u);
    end
    swap_c = (r_c > 13'd2880);
    u_c = swap_c ? 12'(13'd5760 - r_c) : 12'(r_c);
  end

  // fold the octant result back into the quadrant
  always_comb begin
    s0 = swap_r ? coef_t'({1'b0, rom_q_r[16:0]}) : coef_t'({1'b0, rom_q_r[33:17]});
    c0 = swap_r ? coef_t'({1'b0, rom_q_r[33:17]}) : coef_t'({1'b0, rom_q_r[16:0]});
    case (q_r)
      2'd0: begin
        sin_c = s0;
        cos_c = c0;
      end
      2'd1: begin
        sin_c = c0;
        cos_c = -s0;
      end
      2'd2: begin
        sin_c = -s0;
        cos_c = -c0;
      end
      default: begin
        sin_c = -c0;
        cos_c = s0;
      end
    endcase
  end

  // operand selection for the matrix products
  always_comb begin
    opv[OPD_SX]   = sin_r[0];
    opv[OPD_CX]   = cos_r[0];
    opv[OPD_SY]   = sin_r[1];
    opv[OPD_CY]   = cos_r[1];
    opv[OPD_SZ]   = sin_r[2];
    opv[OPD_CZ]   = cos_r[2];
    opv[OPD_K]    = 18'sd65536;
    opv[OPD_NK]   = -18'sd65536;
    opv[OPD_ZERO] = 18'sd0;
    ops = ent_ops(ent_r);
  end

  // round once from Q48 and saturate to Q2.16
  always_comb begin
    v_sum = {ta_r[53], ta_r} + {tb_r[53], tb_r};
    v_rnd = v_sum + 55'sd2147483648;
    ent_wide = v_rnd[54:32];
    if (ent_wide > 23'sd131071) begin
      ent_val = 18'sd131071;
    end else if (ent_wide < -23'sd131072) begin
      ent_val = -18'sd131072;
    end else begin
      ent_val = ent_wide[17:0];
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    ax_nxt = ax_r;
    ent_nxt = ent_r;
    mat_we = 1'b0;
    unique case (state_r)
      ST_IDLE: state_nxt = ST_IDLE;
      ST_RED:  state_nxt = ST_ROM;
      ST_ROM:  state_nxt = ST_QUAD;
      ST_QUAD: begin
        if (ax_r == 2'd2) begin
          ax_nxt = 2'd0;
          ent_nxt = 4'd0;
          state_nxt = ST_MUL1;
        end else begin
          ax_nxt = ax_r + 2'd1;
          state_nxt = ST_RED;
        end
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_ACC;
      ST_ACC: begin
        mat_we = 1'b1;
        if (ent_r == 4'd8) begin
          state_nxt = ST_IDLE;
        end else begin
          ent_nxt = ent_r + 4'd1;
          state_nxt = ST_MUL1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (start) begin
      state_nxt = ST_RED;
      ax_nxt = 2'd0;
    end
  end

  // control state and the matrix itself
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ax_r <= 2'd0;
      ent_r <= 4'd0;
      for (int i = 0; i < 9; i++) begin
        mat_r[i] <= (i % 4 == 0) ? 18'sd65536 : 18'sd0;
      end
    end else begin
      state_r <= state_nxt;
      ax_r <= ax_nxt;
      ent_r <= ent_nxt;
      if (mat_we) begin
        mat_r[ent_r] <= ent_val;
      end
    end
  end

  // working registers of the sequencer
  always_ff @(posedge clk) begin
    rom_q_r <= TRIG_ROM[u_r];
    if (state_r == ST_RED) begin
      u_r <= u_c;
      q_r <= q_c;
      swap_r <= swap_c;
    end
    if (state_r == ST_QUAD) begin
      sin_r[ax_r] <= sin_c;
      cos_r[ax_r] <= cos_c;
    end
    if (state_r == ST_MUL1) begin
      pa_r <= opv[ops.a1] * opv[ops.b1];
      pb_r <= opv[ops.a2] * opv[ops.b2];
    end
    if (state_r == ST_MUL2) begin
      ta_r <= pa_r * opv[ops.c1];
      tb_r <= pb_r * opv[ops.c2];
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign mat = mat_r;

endmodule

[design/vsrt_datapath.sv]
module vsrt_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             busy,
  input  vsrt_pkg::cfg_t   cfg,
  input  vsrt_pkg::mat_t   mat,
  vsrt_in_if.sink          in_ch,
  vsrt_out_if.source       out_ch
);
  import vsrt_pkg::*;

  logic               v1_r, v2_r, v3_r, v4_r;
  logic               rdy1, rdy2, rdy3, rdy4, fire;
  logic signed [47:0] p_r [3];
  logic signed [35:0] sv [3];
  logic signed [47:0] p_rnd [3];
  logic signed [53:0] mp_r [3][3];
  logic signed [55:0] acc [3];
  logic signed [55:0] acc_rnd [3];
  logic signed [39:0] rot_r [3];
  logic signed [31:0] off [3];
  logic signed [40:0] tsum [3];
  logic signed [31:0] res [3];
  logic [2:0]         sat;
  logic signed [31:0] o_r [3];
  logic               clip_r;

  // stage readiness, back to front
  assign rdy4 = !v4_r || out_ch.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1 && !busy;
  assign fire = in_ch.valid && in_ch.ready;

  always_comb begin
    off[0] = cfg.off_x;
    off[1] = cfg.off_y;
    off[2] = cfg.off_z;
    for (int i = 0; i < 3; i++) begin
      p_rnd[i] = p_r[i] + 48'sd2048;
      sv[i] = p_rnd[i][47:12];
      acc[i] = {{2{mp_r[i][0][53]}}, mp_r[i][0]} + {{2{mp_r[i][1][53]}}, mp_r[i][1]}
             + {{2{mp_r[i][2][53]}}, mp_r[i][2]};
      acc_rnd[i] = acc[i] + 56'sd32768;
      tsum[i] = {rot_r[i][39], rot_r[i]} + {{9{off[i][31]}}, off[i]};
      if (tsum[i] > 41'sd2147483647) begin
        res[i] = 32'sh7fffffff;
        sat[i] = 1'b1;
      end else if (tsum[i] < -41'sd2147483648) begin
        res[i] = 32'sh80000000;
        sat[i] = 1'b1;
      end else begin
        res[i] = tsum[i][31:0];
        sat[i] = 1'b0;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= fire;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // payload stages: scale, rotate products, row sums, translate
  always_ff @(posedge clk) begin
    if (rdy1) begin
      p_r[0] <= in_ch.vert_x * $signed(cfg.scale[15:0]);
      p_r[1] <= in_ch.vert_y * $signed(cfg.scale[31:16]);
      p_r[2] <= in_ch.vert_z * $signed(cfg.scale[47:32]);
    end
    if (rdy2) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mp_r[i][j] <= $signed(mat[3 * i + j]) * sv[j];
        end
      end
    end
    if (rdy3) begin
      for (int i = 0; i < 3; i++) begin
        rot_r[i] <= acc_rnd[i][55:16];
      end
    end
    if (rdy4) begin
      for (int i = 0; i < 3; i++) begin
        o_r[i] <= res[i];
      end
      clip_r <= |sat;
    end
  end

  assign out_ch.valid = v4_r;
  assign out_ch.out_x = o_r[0];
  assign out_ch.out_y = o_r[1];
  assign out_ch.out_z = o_r[2];
  assign out_ch.clipped = clip_r;

endmodule

[design/vertex_scale_rotate_translate.sv]
// Vertex transform: each signed Q16.16 vertex is scaled per axis by Q4.12
// factors, rotated by Rz*Ry*Rx and translated, with every coordinate
// saturated and clipped raised when any saturates. The datapath is a
// four-stage pipeline that takes one vertex per cycle when it is not
// stalled; backpressure on the result side stalls only stages that
// are full. Writing an angle register starts a rebuild of the Q2.16
// rotation matrix (three angles through the sine table ROM, then nine
// entries through two pairs of multipliers, each entry in two multiply
// steps and an accumulate step); in_ch.ready stays low until it completes.
module vertex_scale_rotate_translate (
  input  logic        clk,
  input  logic        rst_n,
  vsrt_in_if.sink     in_ch,
  vsrt_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [47:0] cfg_wdata
);
  import vsrt_pkg::*;

  angles_t angles_r;
  cfg_t    cfg_r;
  logic    start;
  logic    busy;
  mat_t    mat;

  assign start = cfg_we && (cfg_idx_t'(cfg_idx) == CFG_ANGLE_X
                         || cfg_idx_t'(cfg_idx) == CFG_ANGLE_Y
                         || cfg_idx_t'(cfg_idx) == CFG_ANGLE_Z);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angles_r <= '0;
      cfg_r.scale <= 48'h1000_1000_1000;
      cfg_r.off_x <= '0;
      cfg_r.off_y <= '0;
      cfg_r.off_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_ANGLE_X:  angles_r[0] <= cfg_wdata[15:0];
        CFG_ANGLE_Y:  angles_r[1] <= cfg_wdata[15:0];
        CFG_ANGLE_Z:  angles_r[2] <= cfg_wdata[15:0];
        CFG_SCALE:    cfg_r.scale <= cfg_wdata;
        CFG_OFFSET_X: cfg_r.off_x <= cfg_wdata[31:0];
        CFG_OFFSET_Y: cfg_r.off_y <= cfg_wdata[31:0];
        CFG_OFFSET_Z: cfg_r.off_z <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  vsrt_matrix_gen u_matrix_gen (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .angles (angles_r),
    .busy   (busy),
    .mat    (mat)
  );

  vsrt_datapath u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .busy   (busy),
    .cfg    (cfg_r),
    .mat    (mat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

[design/vsrt_checker.sv]
module vsrt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_x,
  input logic signed [31:0] out_y,
  input logic signed [31:0] out_z,
  input logic               out_clipped,
  input logic               cfg_we,
  input logic [2:0]         cfg_idx
);
  import vsrt_pkg::*;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // no result straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // clipped only with a coordinate at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      out_x == 32'sh7fffffff || out_x == 32'sh80000000 ||
      out_y == 32'sh7fffffff || out_y == 32'sh80000000 ||
      out_z == 32'sh7fffffff || out_z == 32'sh80000000)
    else $error("clipped without saturated coordinate");

  // an angle write blocks requests while the matrix is rebuilt
  a_rebuild_block: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_idx == 3'(CFG_ANGLE_X) || cfg_idx == 3'(CFG_ANGLE_Y) ||
               cfg_idx == 3'(CFG_ANGLE_Z)) |=> !in_ready)
    else $error("request accepted during matrix rebuild");

endmodule

bind vertex_scale_rotate_translate vsrt_checker u_vsrt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_x       (out_ch.out_x),
  .out_y       (out_ch.out_y),
  .out_z       (out_ch.out_z),
  .out_clipped (out_ch.clipped),
  .cfg_we      (cfg_we),
  .cfg_idx     (cfg_idx)
);

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;
  import vsrt_pkg::*;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_PHASES = 13;
  localparam int PHASE_ITEMS = 146;
  localparam longint TURN = 23040;
  localparam longint QUAD = 5760;
  localparam longint OCT = 2880;
  localparam longint RAD_Q30 = 292818;
  localparam longint UNIT_Q30 = 64'sd1073741824;
  localparam longint UNIT_Q16 = 64'sd65536;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               clipped;
  } vtx_res_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ez;
    logic               eclip;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [47:0] cfg_wdata;

  vsrt_in_if in_ch ();
  vsrt_out_if out_ch ();

  vertex_scale_rotate_translate dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of the configuration and rotation matrix
  logic signed [15:0] angles [3];
  logic [47:0]        scales;
  logic signed [31:0] offsets [3];
  longint             rot [9];

  vtx_res_t pending_q [$];
  vtx_res_t typed_q [$];
  int  fail_cnt;
  int  idle_cycles;
  bit  quiet;
  bit  hold_req;

  // identity transform at reset: output equals input
  dir_row_t reset_rows [8] = '{
    '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{32'h7fffffff, 32'h80000000, 32'sd0, 32'h7fffffff, 32'h80000000, 32'sd0, 1'b0},
    '{32'h80000000, 32'h7fffffff, -32'sd1, 32'h80000000, 32'h7fffffff, -32'sd1, 1'b0},
    '{32'sd1, -32'sd1, 32'h00010000, 32'sd1, -32'sd1, 32'h00010000, 1'b0},
    '{32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'h55555555, 32'haaaaaaaa,
      32'h55555555, 1'b0},
    '{32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555,
      32'haaaaaaaa, 1'b0},
    '{-32'sd65536, 32'sd32768, -32'sd32768, -32'sd65536, 32'sd32768, -32'sd32768, 1'b0},
    '{32'h00012345, 32'hfffedcba, 32'h7fff0000, 32'h00012345, 32'hfffedcba,
      32'h7fff0000, 1'b0}
  };

  // sine and cosine polynomials over one eighth turn, Q16
  function automatic longint poly_sine(longint u);
    longint x, x2, t;
    x = u * RAD_Q30;
    x2 = (x * x) >>> 30;
    t = UNIT_Q30 - x2 / 42;
    t = UNIT_Q30 - ((x2 * t) >>> 30) / 20;
    t = UNIT_Q30 - ((x2 * t) >>> 30) / 6;
    return (((x * t) >>> 30) + 64'sd8192) >>> 14;
  endfunction

  function automatic longint poly_cosine(longint u);
    longint x, x2, t;
    x = u * RAD_Q30;
    x2 = (x * x) >>> 30;
    t = UNIT_Q30 - x2 / 56;
    t = UNIT_Q30 - ((x2 * t) >>> 30) / 30;
    t = UNIT_Q30 - ((x2 * t) >>> 30) / 12;
    t = UNIT_Q30 - ((x2 * t) >>> 30) / 2;
    return (t + 64'sd8192) >>> 14;
  endfunction

  // wrap to one turn, fold into an octant, then restore the quadrant signs
  function automatic void angle_sin_cos(longint a, output longint s, output longint c);
    longint m, q, r, s0, c0;
    m = a % TURN;
    if (m < 0) m += TURN;
    q = m / QUAD;
    r = m % QUAD;
    if (r <= OCT) begin
      s0 = poly_sine(r);
      c0 = poly_cosine(r);
    end else begin
      s0 = poly_cosine(QUAD - r);
      c0 = poly_sine(QUAD - r);
    end
    case (q)
      0: begin s = s0; c = c0; end
      1: begin s = c0; c = -s0; end
      2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endfunction

  // Q48 to Q2.16, round half up, saturate to 18 bits
  function automatic longint coef_from_q48(longint v);
    longint r;
    r = (v + (64'sd1 <<< 31)) >>> 32;
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r;
  endfunction

  function automatic void rebuild_rotation();
    longint sx, cx, sy, cy, sz, cz;
    angle_sin_cos(longint'(angles[0]), sx, cx);
    angle_sin_cos(longint'(angles[1]), sy, cy);
    angle_sin_cos(longint'(angles[2]), sz, cz);
    rot[0] = coef_from_q48(cz * cy * UNIT_Q16);
    rot[1] = coef_from_q48(cz * sy * sx - sz * cx * UNIT_Q16);
    rot[2] = coef_from_q48(cz * sy * cx + sz * sx * UNIT_Q16);
    rot[3] = coef_from_q48(sz * cy * UNIT_Q16);
    rot[4] = coef_from_q48(sz * sy * sx + cz * cx * UNIT_Q16);
    rot[5] = coef_from_q48(sz * sy * cx - cz * sx * UNIT_Q16);
    rot[6] = coef_from_q48(-sy * UNIT_Q16 * UNIT_Q16);
    rot[7] = coef_from_q48(cy * sx * UNIT_Q16);
    rot[8] = coef_from_q48(cy * cx * UNIT_Q16);
  endfunction

  // scale, rotate, translate and saturate one vertex
  function automatic vtx_res_t transform_vertex(logic signed [31:0] x, logic signed [31:0] y,
                                                logic signed [31:0] z);
    longint v [3];
    longint sv [3];
    longint acc, r;
    logic signed [15:0] s;
    logic signed [31:0] o [3];
    vtx_res_t res;
    v[0] = longint'(x);
    v[1] = longint'(y);
    v[2] = longint'(z);
    res.clipped = 1'b0;
    for (int i = 0; i < 3; i++) begin
      s = scales[16*i +: 16];
      sv[i] = (v[i] * longint'(s) + 64'sd2048) >>> 12;
    end
    for (int i = 0; i < 3; i++) begin
      acc = rot[3*i] * sv[0] + rot[3*i+1] * sv[1] + rot[3*i+2] * sv[2];
      r = ((acc + 64'sd32768) >>> 16) + longint'(offsets[i]);
      if (r > 64'sd2147483647) begin
        r = 64'sd2147483647;
        res.clipped = 1'b1;
      end
      if (r < -64'sd2147483648) begin
        r = -64'sd2147483648;
        res.clipped = 1'b1;
      end
      o[i] = r[31:0];
    end
    res.x = o[0];
    res.y = o[1];
    res.z = o[2];
    return res;
  endfunction

  // typed expectation for one directed row
  function automatic void queue_typed(dir_row_t row);
    vtx_res_t e;
    e.x = row.ex;
    e.y = row.ey;
    e.z = row.ez;
    e.clipped = row.eclip;
    typed_q = {typed_q, e};
  endfunction

  // clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // record every accepted vertex with its expected result
  always @(posedge clk) begin
    vtx_res_t e;
    if (in_ch.valid && in_ch.ready) begin
      if (typed_q.size() != 0) e = typed_q.pop_front();
      else e = transform_vertex(in_ch.vert_x, in_ch.vert_y, in_ch.vert_z);
      pending_q = {pending_q, e};
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    vtx_res_t e;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        $error("result with no request outstanding");
        fail_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (out_ch.out_x !== e.x) begin
          $error("out_x expected %0d got %0d", e.x, out_ch.out_x);
          fail_cnt++;
        end
        if (out_ch.out_y !== e.y) begin
          $error("out_y expected %0d got %0d", e.y, out_ch.out_y);
          fail_cnt++;
        end
        if (out_ch.out_z !== e.z) begin
          $error("out_z expected %0d got %0d", e.z, out_ch.out_z);
          fail_cnt++;
        end
        if (out_ch.clipped !== e.clipped) begin
          $error("clipped expected %0b got %0b", e.clipped, out_ch.clipped);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[vertex_scale_rotate_translate] ERROR");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_ANGLE_X:  angles[0] = data[15:0];
      CFG_ANGLE_Y:  angles[1] = data[15:0];
      CFG_ANGLE_Z:  angles[2] = data[15:0];
      CFG_SCALE:    scales = data;
      CFG_OFFSET_X: offsets[0] = data[31:0];
      CFG_OFFSET_Y: offsets[1] = data[31:0];
      CFG_OFFSET_Z: offsets[2] = data[31:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // full reprogram, including a write to the unused index
  task automatic load_transform(logic signed [15:0] ax, logic signed [15:0] ay,
                                logic signed [15:0] az, logic [47:0] sc,
                                logic signed [31:0] ox, logic signed [31:0] oy,
                                logic signed [31:0] oz);
    write_reg(CFG_ANGLE_X, {{32{ax[15]}}, ax});
    write_reg(CFG_ANGLE_Y, {{32{ay[15]}}, ay});
    write_reg(CFG_ANGLE_Z, {{32{az[15]}}, az});
    write_reg(CFG_SCALE, sc);
    write_reg(CFG_OFFSET_X, {{16{ox[31]}}, ox});
    write_reg(CFG_OFFSET_Y, {{16{oy[31]}}, oy});
    write_reg(CFG_OFFSET_Z, {{16{oz[31]}}, oz});
    write_reg(CFG_UNUSED, 48'({$urandom, $urandom}));
    cfg_we <= 1'b0;
    rebuild_rotation();
    @(posedge clk);
  endtask

  // hold the request until the edge at which it is taken
  task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.vert_x <= x;
    in_ch.vert_y <= y;
    in_ch.vert_z <= z;
    @(posedge clk iff in_ch.ready);
  endtask

  // drop valid and let every result drain before touching registers
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return $urandom_range(1, 0) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(0, 32'h001fffff)) - 32'sd1048576;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 7))
      0: return 16'sd23040;
      1: return -16'sd23040;
      2: return 16'($urandom);
      3: return 16'(32'sd5760 * $signed($urandom_range(0, 7) - 4));
      default: return 16'($signed($urandom_range(0, 46080)) - 32'sd23040);
    endcase
  endfunction

  function automatic logic [15:0] rand_scale();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 16384)) - 32'sd8192);
  endfunction

  function automatic logic signed [31:0] rand_offset();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h01ffffff)) - 32'sd16777216;
  endfunction

  // stimulus
  initial begin
    fail_cnt = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.vert_x = '0;
    in_ch.vert_y = '0;
    in_ch.vert_z = '0;
    angles = '{default: '0};
    offsets = '{default: '0};
    scales = 48'h1000_1000_1000;
    rebuild_rotation();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity at reset
    foreach (reset_rows[i]) begin
      queue_typed(reset_rows[i]);
      send_vertex(reset_rows[i].x, reset_rows[i].y, reset_rows[i].z);
    end
    drain();

    // directed: quarter turn, full-turn wrap, out-of-range angles, negative scales,
    // saturating offsets
    load_transform(16'sd5760, 16'sd0, 16'sd0, 48'h1000_1000_1000, 0, 0, 0);
    send_vertex(32'sd65536, 32'sd131072, -32'sd65536);
    send_vertex(32'h7fffffff, 32'h80000000, 32'sd1);
    drain();
    load_transform(16'sd23040, -16'sd23040, 16'sd11520, 48'h2000_0800_f000,
                   32'sd65536, -32'sd65536, 32'sd0);
    send_vertex(32'sd65536, 32'sd65536, 32'sd65536);
    send_vertex(32'h80000000, 32'h7fffffff, 32'h80000000);
    drain();
    load_transform(16'sh7fff, 16'sh8000, 16'sd1, 48'h8000_8000_8000,
                   32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_vertex(32'h80000000, 32'h80000000, 32'h80000000);
    send_vertex(32'sd0, 32'sd0, 32'sd0);
    drain();
    load_transform(16'sd0, 16'sd0, 16'sd0, 48'h7fff_7fff_7fff,
                   32'sh80000000, 32'sh7fffffff, 32'sd0);
    send_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_vertex(32'sd0, 32'sd0, -32'sd65536);
    drain();

    // random phases, each under a fresh transform
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: load_transform(16'sd23040, 16'sd23040, 16'sd23040, 48'hffff_ffff_ffff,
                          32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        1: load_transform(-16'sd23040, -16'sd23040, -16'sd23040, 48'h0,
                          32'sh80000000, 32'sh80000000, 32'sh80000000);
        default: load_transform(rand_angle(), rand_angle(), rand_angle(),
                                {rand_scale(), rand_scale(), rand_scale()},
                                rand_offset(), rand_offset(), rand_offset());
      endcase
      if (p == 3) hold_req = 1'b1;
      if (p == RAND_PHASES - 1) quiet = 1'b1;
      repeat (PHASE_ITEMS) send_vertex(rand_coord(), rand_coord(), rand_coord());
      drain();
    end

    if (fail_cnt == 0) begin
      $display("[vertex_scale_rotate_translate] OK");
    end else begin
      $display("[vertex_scale_rotate_translate] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
design/vsrt_pkg.sv
design/vsrt_in_if.sv
design/vsrt_out_if.sv
design/vsrt_matrix_gen.sv
design/vsrt_datapath.sv
design/vertex_scale_rotate_translate.sv
design/vsrt_checker.sv
dv/tb.sv
